[sv/sglm_pkg.sv]
// Shared types and constants of the sequence gap loss monitor.
package sglm_pkg;

	localparam int CNT_W    = 32;
	localparam int SEQ_W    = 32;
	localparam int TIME_W   = 32;
	localparam int WIN_W    = 64;
	localparam int LEN_W    = 7;
	localparam int DATA_W   = 32;
	localparam int ADDR_W   = 3;
	localparam int REGIDX_W = ADDR_W - 2;

	localparam logic [REGIDX_W-1:0] REG_HISTORY_LENGTH = REGIDX_W'(0);
	localparam logic [LEN_W-1:0]    HIST_LEN_RESET     = LEN_W'(32);

	typedef struct packed {
		logic                     has_previous;
		logic                     fields_valid;
		logic signed [SEQ_W-1:0]  new_sequence;
		logic signed [SEQ_W-1:0]  old_sequence;
		logic [TIME_W-1:0]        new_start_time;
		logic [TIME_W-1:0]        old_start_time;
	} report_t;

	typedef struct packed {
		logic             sequenced;
		logic [CNT_W-1:0] lost;
	} loss_t;

endpackage

[sv/sglm_classify.sv]
// Loss classification of one update report from its sequence numbers and start times.
module sglm_classify (
	input  sglm_pkg::report_t rep,
	output sglm_pkg::loss_t   info
);
	import sglm_pkg::*;

	localparam int DIFF_W = SEQ_W + 2;

	logic [DIFF_W-1:0] diff;
	logic              active;

	// Gap to the expected sequence number, new - (old + 1), without wrap.
	assign diff = {{2{rep.new_sequence[SEQ_W-1]}}, rep.new_sequence}
		- {{2{rep.old_sequence[SEQ_W-1]}}, rep.old_sequence}
		- DIFF_W'(1);

	assign active = rep.has_previous && rep.fields_valid;

	always_comb begin
		info.sequenced = active;
		info.lost      = '0;
		if (active && (rep.new_start_time == rep.old_start_time) && (diff != '0)) begin
			if (diff[DIFF_W-1]) begin
				info.lost = CNT_W'(1);
			end else begin
				// A positive gap is at most 2^32 - 2, so it always fits.
				info.lost = diff[CNT_W-1:0];
			end
		end
	end

endmodule

[sv/sglm_stats.sv]
// Saturating update counters, loss history shift register and result registers.
module sglm_stats #(
	parameter int HIST_W = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  sglm_pkg::loss_t               info,
	input  logic [sglm_pkg::LEN_W-1:0]    hist_len,
	output logic [sglm_pkg::CNT_W-1:0]    total_updates,
	output logic [sglm_pkg::CNT_W-1:0]    sequenced_updates,
	output logic [sglm_pkg::CNT_W-1:0]    lost_updates,
	output logic [sglm_pkg::CNT_W-1:0]    lost_this_item,
	output logic [sglm_pkg::WIN_W-1:0]    history_window
);
	import sglm_pkg::*;

	localparam int SH_W = (HIST_W > 1) ? $clog2(HIST_W) : 1;

	logic [CNT_W-1:0]  total_q;
	logic [CNT_W-1:0]  seq_q;
	logic [CNT_W-1:0]  lost_q;
	logic [CNT_W-1:0]  lost_item_q;
	logic [HIST_W-1:0] hist_q;
	logic [WIN_W-1:0]  window_q;

	logic [CNT_W-1:0]  seq_inc;
	logic [LEN_W-1:0]  shown;
	logic [SH_W-1:0]   sh;
	logic [HIST_W-1:0] hist_d;
	logic [WIN_W-1:0]  window_d;

	function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
		input logic [CNT_W-1:0] b);
		logic [CNT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
	endfunction

	assign seq_inc = !info.sequenced ? '0 :
		((info.lost != '0) ? info.lost : CNT_W'(1));
	assign shown = (hist_len > LEN_W'(HIST_W)) ? LEN_W'(HIST_W) : hist_len;
	assign sh    = info.lost[SH_W-1:0];

	always_comb begin
		if (shown == '0) begin
			hist_d = '0;
		end else if (info.lost == '0) begin
			hist_d = hist_q << 1;
		end else if (info.lost >= CNT_W'(HIST_W)) begin
			hist_d = {HIST_W{1'b1}};
		end else begin
			hist_d = (hist_q << sh) | ~({HIST_W{1'b1}} << sh);
		end
	end

	assign window_d = WIN_W'(hist_d) & ~({WIN_W{1'b1}} << shown);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			seq_q   <= '0;
			lost_q  <= '0;
			hist_q  <= '0;
		end else if (load) begin
			total_q <= sat_add(total_q, CNT_W'(1));
			seq_q   <= sat_add(seq_q, seq_inc);
			lost_q  <= sat_add(lost_q, info.lost);
			hist_q  <= hist_d;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			lost_item_q <= info.lost;
			window_q    <= window_d;
		end
	end

	assign total_updates     = total_q;
	assign sequenced_updates = seq_q;
	assign lost_updates      = lost_q;
	assign lost_this_item    = lost_item_q;
	assign history_window    = window_q;

endmodule

[sv/sequence_gap_loss_monitor.sv]
// Top level of the sequence gap loss monitor: input register, handshake and register port.
//
//  Channel   Direction  Handshake                 Word
//  input     in         in_valid / in_stall       one update report
//  output    out        out_valid / out_stall     counters, loss and history window
//  register  in         APB write, pready high    history_length at byte address 0
//
// One report is accepted in every cycle in which in_stall is low; its result is set by the
// result register that follows the input register, with the counter update between.
// Reset clears the counters and the history and sets history_length to 32.
// A stalled result holds; in_stall rises only while the input register is full and the
// result waits, so one report is still taken while a finished word waits to be taken.
module sequence_gap_loss_monitor #(
	parameter int HISTORY_MAX = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [sglm_pkg::ADDR_W-1:0]          paddr,
	input  logic [sglm_pkg::DATA_W-1:0]          pwdata,
	output logic [sglm_pkg::DATA_W-1:0]          prdata,
	output logic                                 pready,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 has_previous,
	input  logic                                 fields_valid,
	input  logic signed [sglm_pkg::SEQ_W-1:0]    new_sequence,
	input  logic signed [sglm_pkg::SEQ_W-1:0]    old_sequence,
	input  logic [sglm_pkg::TIME_W-1:0]          new_start_time,
	input  logic [sglm_pkg::TIME_W-1:0]          old_start_time,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [sglm_pkg::CNT_W-1:0]           total_updates,
	output logic [sglm_pkg::CNT_W-1:0]           sequenced_updates,
	output logic [sglm_pkg::CNT_W-1:0]           lost_updates,
	output logic [sglm_pkg::CNT_W-1:0]           lost_this_item,
	output logic [sglm_pkg::WIN_W-1:0]           history_window
);
	import sglm_pkg::*;

	logic [LEN_W-1:0] hist_len_q;
	logic             valid_s1;
	report_t          rep_s1;
	logic             out_valid_q;
	logic             move;
	logic             accept_in;
	logic             cfg_write;
	loss_t            info;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign prdata    = (paddr[ADDR_W-1:2] == REG_HISTORY_LENGTH) ? DATA_W'(hist_len_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_len_q <= HIST_LEN_RESET;
		end else if (cfg_write && (paddr[ADDR_W-1:2] == REG_HISTORY_LENGTH)) begin
			hist_len_q <= pwdata[LEN_W-1:0];
		end
	end

	assign move      = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !move;
	assign accept_in = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept_in) begin
				valid_s1 <= 1'b1;
			end else if (move) begin
				valid_s1 <= 1'b0;
			end
			if (move) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			rep_s1.has_previous   <= has_previous;
			rep_s1.fields_valid   <= fields_valid;
			rep_s1.new_sequence   <= new_sequence;
			rep_s1.old_sequence   <= old_sequence;
			rep_s1.new_start_time <= new_start_time;
			rep_s1.old_start_time <= old_start_time;
		end
	end

	sglm_classify u_classify (
		.rep  (rep_s1),
		.info (info)
	);

	sglm_stats #(
		.HIST_W (HISTORY_MAX)
	) u_stats (
		.clk               (clk),
		.arst_n            (arst_n),
		.load              (move),
		.info              (info),
		.hist_len          (hist_len_q),
		.total_updates     (total_updates),
		.sequenced_updates (sequenced_updates),
		.lost_updates      (lost_updates),
		.lost_this_item    (lost_this_item),
		.history_window    (history_window)
	);

	assign out_valid = out_valid_q;

endmodule

[sv/sglm_checker.sv]
// Port-level checks of the sequence gap loss monitor and their binding to the top level.
module sglm_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [sglm_pkg::CNT_W-1:0]    total_updates,
	input logic [sglm_pkg::CNT_W-1:0]    sequenced_updates,
	input logic [sglm_pkg::CNT_W-1:0]    lost_updates,
	input logic [sglm_pkg::CNT_W-1:0]    lost_this_item,
	input logic [sglm_pkg::WIN_W-1:0]    history_window
);
	import sglm_pkg::*;

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(total_updates)
			&& $stable(lost_this_item) && $stable(history_window))
		else $error("Result word changed while stalled.");

	a_total_advances: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall |=> !out_valid
			|| total_updates != $past(total_updates)
			|| total_updates == {CNT_W{1'b1}})
		else $error("Consecutive result words carry the same total count.");

	a_lost_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> lost_this_item <= lost_updates && lost_updates <= sequenced_updates)
		else $error("Loss counts out of order.");

	a_history_good: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && lost_this_item == '0 |-> !history_window[0])
		else $error("Newest history bit marks a loss for a good update.");

endmodule

bind sequence_gap_loss_monitor sglm_checker u_sglm_checker (.*);

[verif/sequence_gap_loss_monitor_test.sv]
`timescale 1ns / 1ps
// Testbench of the sequence gap loss monitor: directed and random reports checked against a predictor.
module sequence_gap_loss_monitor_test;
	import sglm_pkg::*;

	localparam logic [REGIDX_W-1:0] REG_SPARE = REGIDX_W'(1);
	localparam int SETTLE_CYCLES = 4;

	typedef enum logic [3:0] {
		DRV_RUN    = 4'b0001,
		DRV_DRAIN  = 4'b0010,
		DRV_SETUP  = 4'b0100,
		DRV_ACCESS = 4'b1000
	} drv_state_t;

	typedef struct packed {
		logic [CNT_W-1:0] total;
		logic [CNT_W-1:0] sequenced;
		logic [CNT_W-1:0] lost_sum;
		logic [CNT_W-1:0] lost_now;
		logic [WIN_W-1:0] window;
	} tally_t;

	typedef struct {
		bit                  is_cfg;
		logic [REGIDX_W-1:0] reg_idx;
		logic [DATA_W-1:0]   reg_val;
		report_t             rpt;
	} pending_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	report_t cur_rpt = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [CNT_W-1:0] total_updates;
	logic [CNT_W-1:0] sequenced_updates;
	logic [CNT_W-1:0] lost_updates;
	logic [CNT_W-1:0] lost_this_item;
	logic [WIN_W-1:0] history_window;

	pending_t pending_q[$];
	tally_t tally_q[$];
	drv_state_t drv_state = DRV_RUN;
	int gap_left = 0;
	int stall_left = 0;
	int settle = 0;
	int reports_sent = 0;
	int results_seen = 0;
	int mismatches = 0;
	bit in_calm = 1'b0;
	bit out_calm = 1'b0;
	logic [31:0] s_seq;
	logic [31:0] s_time;

	logic [LEN_W-1:0] hist_len = HIST_LEN_RESET;
	logic [CNT_W-1:0] cnt_total = '0;
	logic [CNT_W-1:0] cnt_seq = '0;
	logic [CNT_W-1:0] cnt_lost = '0;
	logic [WIN_W-1:0] hist_reg = '0;

	sequence_gap_loss_monitor u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.has_previous(cur_rpt.has_previous),
		.fields_valid(cur_rpt.fields_valid),
		.new_sequence(cur_rpt.new_sequence),
		.old_sequence(cur_rpt.old_sequence),
		.new_start_time(cur_rpt.new_start_time),
		.old_start_time(cur_rpt.old_start_time),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.total_updates(total_updates),
		.sequenced_updates(sequenced_updates),
		.lost_updates(lost_updates),
		.lost_this_item(lost_this_item),
		.history_window(history_window)
	);

	function automatic logic [CNT_W-1:0] sat_sum(input logic [CNT_W-1:0] a,
			input logic [CNT_W-1:0] b);
		logic [CNT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[CNT_W] ? '1 : s[CNT_W-1:0];
	endfunction

	// The expected sequence is formed in 33 bits, so the largest sequence number never wraps.
	function automatic tally_t account_report(input report_t r);
		logic signed [SEQ_W:0] want;
		logic signed [SEQ_W:0] got;
		logic [SEQ_W:0] gap;
		logic [CNT_W-1:0] lost;
		int shown;
		tally_t t;
		lost = '0;
		if (r.has_previous && r.fields_valid) begin
			want = {r.old_sequence[SEQ_W-1], r.old_sequence} + 33'sd1;
			got = {r.new_sequence[SEQ_W-1], r.new_sequence};
			if (r.new_start_time == r.old_start_time && got != want) begin
				if (got < want) begin
					lost = 32'd1;
				end else begin
					gap = got - want;
					lost = gap[SEQ_W] ? '1 : gap[SEQ_W-1:0];
				end
			end
			cnt_seq = sat_sum(cnt_seq, (lost != 0) ? lost : 32'd1);
		end
		cnt_lost = sat_sum(cnt_lost, lost);
		cnt_total = sat_sum(cnt_total, 32'd1);
		shown = (int'(hist_len) > WIN_W) ? WIN_W : int'(hist_len);
		if (shown == 0) begin
			hist_reg = '0;
		end else if (lost == 0) begin
			hist_reg = hist_reg << 1;
		end else if (lost >= WIN_W) begin
			hist_reg = '1;
		end else begin
			hist_reg = (hist_reg << lost) | ((64'd1 << lost) - 64'd1);
		end
		t.total = cnt_total;
		t.sequenced = cnt_seq;
		t.lost_sum = cnt_lost;
		t.lost_now = lost;
		t.window = (shown == WIN_W) ? hist_reg : hist_reg & ((64'd1 << shown) - 64'd1);
		return t;
	endfunction

	function automatic int pick_wait(inout bit calm);
		int roll;
		if ($urandom_range(0, 79) == 0)
			calm = !calm;
		if (calm)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	task automatic check_field(input string what, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("Mismatch in %s: expected %h, got %h", what, want, got);
		end
	endtask

	task automatic add_report(input logic hp, input logic fv, input logic [31:0] nseq,
			input logic [31:0] oseq, input logic [31:0] ntime, input logic [31:0] otime);
		pending_t p;
		p.is_cfg = 1'b0;
		p.reg_idx = '0;
		p.reg_val = '0;
		p.rpt.has_previous = hp;
		p.rpt.fields_valid = fv;
		p.rpt.new_sequence = nseq;
		p.rpt.old_sequence = oseq;
		p.rpt.new_start_time = ntime;
		p.rpt.old_start_time = otime;
		pending_q.push_back(p);
	endtask

	task automatic add_write(input logic [REGIDX_W-1:0] idx, input logic [DATA_W-1:0] val);
		pending_t p;
		p.is_cfg = 1'b1;
		p.reg_idx = idx;
		p.reg_val = val;
		p.rpt = '0;
		pending_q.push_back(p);
	endtask

	// Mostly a well-behaved sender with random content, with some noise mixed in.
	task automatic gen_traffic(input int n);
		int roll;
		logic hp;
		logic fv;
		logic [31:0] nseq;
		logic [31:0] oseq;
		logic [31:0] ntime;
		logic [31:0] otime;
		for (int i = 0; i < n; i++) begin
			roll = $urandom_range(0, 99);
			if (roll < 80) begin
				hp = 1'b1;
				fv = 1'b1;
				ntime = s_time;
				roll = $urandom_range(0, 99);
				if (roll < 55) begin
					nseq = s_seq + 32'd1;
				end else if (roll < 70) begin
					nseq = s_seq + $urandom_range(2, 8);
				end else if (roll < 76) begin
					nseq = s_seq + $urandom_range(9, 90);
				end else if (roll < 86) begin
					nseq = s_seq - $urandom_range(0, 4);
				end else if (roll < 92) begin
					nseq = $urandom;
					ntime = $urandom;
				end else if (roll < 96) begin
					fv = 1'b0;
					nseq = s_seq + $urandom_range(1, 5);
				end else begin
					hp = 1'b0;
					ntime = $urandom;
					if ($urandom_range(0, 3) == 0)
						nseq = 32'h7FFF_FFF0 + $urandom_range(0, 15);
					else
						nseq = $urandom;
				end
				add_report(hp, fv, nseq, s_seq, ntime, s_time);
				s_seq = nseq;
				s_time = ntime;
			end else begin
				oseq = $urandom;
				otime = $urandom;
				if (roll < 90) begin
					ntime = otime;
					nseq = oseq + $urandom_range(0, 200) - 32'd100;
				end else begin
					ntime = $urandom;
					nseq = $urandom;
				end
				add_report(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					nseq, oseq, ntime, otime);
			end
		end
	endtask

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

	always @(posedge clk) begin : driver
		logic nxt_valid;
		pending_t nxt;
		if (arst_n) begin
			nxt_valid = in_valid;
			if (in_valid && !in_stall) begin
				tally_q.push_back(account_report(cur_rpt));
				reports_sent++;
				nxt_valid = 1'b0;
			end
			case (drv_state)
			DRV_RUN: begin
				if (!nxt_valid) begin
					if (gap_left != 0) begin
						gap_left--;
					end else if (pending_q.size() != 0) begin
						if (pending_q[0].is_cfg) begin
							drv_state = DRV_DRAIN;
							settle = 0;
						end else begin
							nxt = pending_q.pop_front();
							cur_rpt <= nxt.rpt;
							nxt_valid = 1'b1;
							gap_left = pick_wait(in_calm);
						end
					end
				end
			end
			DRV_DRAIN: begin
				if (reports_sent == results_seen && !out_valid) begin
					if (settle >= SETTLE_CYCLES) begin
						nxt = pending_q[0];
						psel <= 1'b1;
						pwrite <= 1'b1;
						paddr <= ADDR_W'({nxt.reg_idx, 2'b00});
						pwdata <= nxt.reg_val;
						drv_state = DRV_SETUP;
					end else begin
						settle++;
					end
				end else begin
					settle = 0;
				end
			end
			DRV_SETUP: begin
				penable <= 1'b1;
				drv_state = DRV_ACCESS;
			end
			DRV_ACCESS: begin
				if (pready) begin
					nxt = pending_q.pop_front();
					if (nxt.reg_idx == REG_HISTORY_LENGTH)
						hist_len = nxt.reg_val[LEN_W-1:0];
					psel <= 1'b0;
					penable <= 1'b0;
					pwrite <= 1'b0;
					drv_state = DRV_RUN;
				end
			end
			default: begin
				drv_state = DRV_RUN;
			end
			endcase
			in_valid <= nxt_valid;
		end
	end

	always @(posedge clk) begin : monitor
		tally_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				results_seen <= results_seen + 1;
				if (tally_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Unexpected word: total %0d, lost %0d", total_updates,
							lost_this_item);
				end else begin
					want = tally_q.pop_front();
					check_field("total_updates", 64'(want.total), 64'(total_updates));
					check_field("sequenced_updates", 64'(want.sequenced),
						64'(sequenced_updates));
					check_field("lost_updates", 64'(want.lost_sum), 64'(lost_updates));
					check_field("lost_this_item", 64'(want.lost_now), 64'(lost_this_item));
					check_field("history_window", want.window, history_window);
				end
			end
			if (stall_left != 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
				stall_left = pick_wait(out_calm);
			end
		end
	end

	initial begin
		s_seq = $urandom;
		s_time = $urandom;

		add_report(1'b0, 1'b1, 32'd5, 32'd4, 32'd7, 32'd7);
		add_report(1'b1, 1'b0, 32'd100, 32'd4, 32'd7, 32'd7);
		add_report(1'b1, 1'b1, 32'd5, 32'd4, 32'd7, 32'd7);
		add_report(1'b1, 1'b1, 32'd3, 32'd4, 32'd7, 32'd7);
		add_report(1'b1, 1'b1, 32'd4, 32'd4, 32'd7, 32'd7);
		add_report(1'b1, 1'b1, 32'd50, 32'd4, 32'd8, 32'd7);
		add_report(1'b1, 1'b1, 32'd10, 32'd4, 32'd7, 32'd7);
		add_report(1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'd7, 32'd7);
		add_report(1'b1, 1'b1, 32'd0, 32'hFFFF_FFFF, 32'd7, 32'd7);
		add_report(1'b1, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'd0);
		add_report(1'b1, 1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		add_report(1'b1, 1'b1, 32'h8000_0000, 32'h8000_0000, 32'd1, 32'd1);
		add_report(1'b1, 1'b1, 32'd1, 32'd0, 32'd0, 32'hFFFF_FFFF);
		add_report(1'b0, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		add_write(REG_HISTORY_LENGTH, 32'd64);
		add_report(1'b1, 1'b1, 32'd64, 32'd0, 32'd9, 32'd9);
		add_report(1'b1, 1'b1, 32'd1, 32'd0, 32'd9, 32'd9);
		add_report(1'b1, 1'b1, 32'd65, 32'd0, 32'd9, 32'd9);
		add_report(1'b1, 1'b1, 32'd1, 32'd0, 32'd9, 32'd9);
		add_report(1'b1, 1'b1, 32'd66, 32'd0, 32'd9, 32'd9);
		add_report(1'b1, 1'b1, 32'd1, 32'd0, 32'd9, 32'd9);

		gen_traffic(130);
		add_write(REG_HISTORY_LENGTH, 32'd0);
		gen_traffic(90);
		add_write(REG_SPARE, 32'd5);
		gen_traffic(20);
		add_write(REG_HISTORY_LENGTH, 32'd1);
		gen_traffic(90);
		add_write(REG_HISTORY_LENGTH, 32'd127);
		gen_traffic(100);
		add_write(REG_HISTORY_LENGTH, 32'h0000_0085);
		gen_traffic(60);
		add_write(REG_HISTORY_LENGTH, 32'($urandom_range(2, 63)));
		gen_traffic(120);
		add_write(REG_HISTORY_LENGTH, 32'd64);
		gen_traffic(110);
		for (int i = 0; i < 3; i++)
			add_report(1'b1, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'd3, 32'd3);
		gen_traffic(10);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		do @(negedge clk);
		while (pending_q.size() != 0 || drv_state != DRV_RUN || in_valid);
		do @(negedge clk);
		while (reports_sent != results_seen);
		repeat (8) @(posedge clk);

		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
